// File: rtl/bucketed_score_table_assert.svh
// Assertion macros shared by the checker files of the bucketed score table.
// Depends on nothing; included by bst_checker.sv.
`ifndef BUCKETED_SCORE_TABLE_ASSERT_SVH
`define BUCKETED_SCORE_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BST_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BST_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bst_pkg.sv
// Shared types and constants of the bucketed score table.
// Depends on nothing; used by the row memory, the way unit and the top level.
`default_nettype none

package bst_pkg;

   localparam int MAX_INDEX_BITS_DEF = 12;
   localparam int WAYS_DEF           = 4;
   localparam int SAMPLE_BUCKETS     = 1000;
   localparam int KEY_W              = 32;
   localparam int SCORE_W            = 16;
   localparam int FILL_W             = 10;
   localparam int CSR_W              = 4;
   localparam logic [CSR_W-1:0] INDEX_BITS_RESET = 4'd12;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_FILL   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FILL,
      ST_FILL_TAIL,
      ST_DIV,
      ST_CLEAR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [SCORE_W-1:0] score;
   } slot_type;

   typedef struct packed {
      logic key_eq;
      logic empty;
      logic lt_new;
      logic lt_low;
   } way_flags_type;

endpackage

`default_nettype wire

// File: rtl/bst_row_mem.sv
// Bucket row memory of the bucketed score table: one row of all ways per bucket.
// Depends on bst_pkg; one write port and one registered read port.
`default_nettype none

module bst_row_mem #(
   parameter int ROW_W = 12,
   parameter int WAYS  = 4
) (
   input  wire                                 clock,
   input  wire                                 wr_en,
   input  wire  [ROW_W-1:0]                    wr_addr,
   input  wire  bst_pkg::slot_type [WAYS-1:0]  wr_data,
   input  wire                                 rd_en,
   input  wire  [ROW_W-1:0]                    rd_addr,
   output bst_pkg::slot_type [WAYS-1:0]        rd_data
);
   import bst_pkg::*;

   localparam int DEPTH = 1 << ROW_W;

   slot_type [WAYS-1:0] mem_q [DEPTH];
   slot_type [WAYS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bst_way_unit.sv
// Shared compare unit of the bucketed score table, applied to one way per cycle.
// Depends on bst_pkg.
`default_nettype none

module bst_way_unit (
   input  wire        bst_pkg::slot_type            slot,
   input  wire        [bst_pkg::KEY_W-1:0]          new_key,
   input  wire signed [bst_pkg::SCORE_W-1:0]        new_score,
   input  wire signed [bst_pkg::SCORE_W-1:0]        low_score,
   output bst_pkg::way_flags_type                   flags
);
   import bst_pkg::*;

   always_comb begin
      flags.key_eq = (slot.key == new_key);
      flags.empty  = (slot.key == '0) && (slot.score == '0);
      flags.lt_new = (slot.score < new_score);
      flags.lt_low = (slot.score < low_score);
   end

endmodule

`default_nettype wire

// File: rtl/bucketed_score_table.sv
// Top level of the bucketed score table: sequencer, fill divider and output register.
// Depends on bst_pkg, bst_row_mem and bst_way_unit.
//
//   Channel  Direction  Transfer when            Contents
//   req      in         req_tvalid & req_tready  tuser op, tdata key and score
//   rsp      out        rsp_tvalid & rsp_tready  tuser success, tdata score and fill
//   csr      in         csr_wr_en                index_bits
//
// Add and look up read the row, pass one way per cycle through the shared compare
// unit, write the row back for an add that changes it and then load the output.
// A fill query reads one row per bucket for min(1000, buckets) buckets, counts the
// last row, multiplies by the reciprocal of WAYS and loads the output.
// A clear writes all 2^MAX_INDEX_BITS rows to zero.
// After reset the block sweeps all 2^MAX_INDEX_BITS rows to zero before req_tready rises.
// A stalled result holds the sequencer in its final state until the transfer.
`default_nettype none

module bucketed_score_table #(
   parameter int MAX_INDEX_BITS = bst_pkg::MAX_INDEX_BITS_DEF,
   parameter int WAYS           = bst_pkg::WAYS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [47:0]                req_tdata,   // key[31:0], score[47:32]
   input  wire  [1:0]                 req_tuser,   // op[1:0]
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   output logic [31:0]                rsp_tdata,   // found_score[15:0], fill_permill[25:16]
   output logic                       rsp_tuser,   // success
   input  wire                        csr_wr_en,
   input  wire  [bst_pkg::CSR_W-1:0]  csr_wr_data  // index_bits[3:0]
);
   import bst_pkg::*;

   localparam int ROW_W   = MAX_INDEX_BITS;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int USED_W  = $clog2(SAMPLE_BUCKETS * WAYS + 1);
   localparam int DIV_SH  = USED_W + WAY_W;
   localparam int DIV_MUL = ((1 << DIV_SH) + WAYS - 1) / WAYS;
   localparam int PROD_W  = USED_W + DIV_SH + 1;
   localparam int CMP_W   = (ROW_W > FILL_W) ? ROW_W : FILL_W;

   state_type                  state_ff, state_in;
   logic [CSR_W-1:0]           index_bits_ff;
   op_type                     op_ff;
   logic [KEY_W-1:0]           key_ff;
   logic signed [SCORE_W-1:0]  score_ff;
   logic [ROW_W-1:0]           row_ff;
   logic [ROW_W-1:0]           last_row_ff;
   logic [WAY_W-1:0]           way_ff;
   logic                       match_ff, match_lt_ff;
   logic [WAY_W-1:0]           match_idx_ff;
   logic signed [SCORE_W-1:0]  match_score_ff;
   logic                       empty_ff;
   logic [WAY_W-1:0]           empty_idx_ff;
   logic [WAY_W-1:0]           low_idx_ff;
   logic signed [SCORE_W-1:0]  low_score_ff;
   logic                       low_lt_ff;
   logic                       res_ok_ff;
   logic signed [SCORE_W-1:0]  res_score_ff;
   logic                       pend_ff;
   logic [USED_W-1:0]          used_ff;
   logic                       rsp_tvalid_ff;
   logic                       rsp_tuser_ff;
   logic [SCORE_W-1:0]         rsp_score_ff;
   logic [FILL_W-1:0]          rsp_fill_ff;

   logic                       req_fire;
   op_type                     req_op;
   logic [ROW_W-1:0]           req_row;
   logic [ROW_W-1:0]           mask_row;
   logic [ROW_W-1:0]           fill_last;
   logic                       out_free;

   logic                       mem_wr_en;
   logic [ROW_W-1:0]           mem_wr_addr;
   slot_type [WAYS-1:0]        mem_wr_data;
   logic                       mem_rd_en;
   logic [ROW_W-1:0]           mem_rd_addr;
   slot_type [WAYS-1:0]        mem_rd_data;

   slot_type                   cur_slot;
   way_flags_type              flags;
   logic                       way_last;
   logic                       dec_write;
   logic                       dec_ok;
   logic [WAY_W-1:0]           dec_idx;
   logic [USED_W-1:0]          row_pop;
   logic [PROD_W-1:0]          div_prod;

   bst_row_mem #(
      .ROW_W (ROW_W),
      .WAYS  (WAYS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign cur_slot = mem_rd_data[way_ff];

   bst_way_unit u_way (
      .slot      (cur_slot),
      .new_key   (key_ff),
      .new_score (score_ff),
      .low_score (low_score_ff),
      .flags     (flags)
   );

   assign req_op   = op_type'(req_tuser);
   assign req_fire = req_tvalid && req_tready;
   assign way_last = (way_ff == WAY_W'(WAYS - 1));
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      for (int b = 0; b < ROW_W; b++) begin
         mask_row[b] = (int'(index_bits_ff) > b);
         req_row[b]  = req_tdata[b] && mask_row[b];
      end
      if (CMP_W'(mask_row) >= CMP_W'(SAMPLE_BUCKETS)) begin
         fill_last = ROW_W'(SAMPLE_BUCKETS - 1);
      end else begin
         fill_last = mask_row;
      end
   end

   always_comb begin
      row_pop = '0;
      for (int w = 0; w < WAYS; w++) begin
         row_pop = row_pop + USED_W'(mem_rd_data[w].key != '0);
      end
   end

   // The reciprocal is rounded up with enough fraction bits to give the exact quotient.
   assign div_prod = PROD_W'(used_ff) * PROD_W'(DIV_MUL);

   always_comb begin
      dec_write = 1'b0;
      dec_ok    = 1'b0;
      dec_idx   = low_idx_ff;
      if (op_ff == OP_ADD) begin
         if (match_ff) begin
            dec_idx   = match_idx_ff;
            dec_write = match_lt_ff;
         end else if (empty_ff) begin
            dec_idx   = empty_idx_ff;
            dec_write = 1'b1;
         end else begin
            dec_idx   = low_idx_ff;
            dec_write = low_lt_ff;
         end
         dec_ok = dec_write;
      end else begin
         dec_ok = match_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (row_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_ADD:    state_in = ST_SCAN;
                  OP_LOOKUP: state_in = ST_SCAN;
                  OP_FILL:   state_in = ST_FILL;
                  OP_CLEAR:  state_in = ST_CLEAR;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (way_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE:    state_in = ST_DONE;
         ST_FILL: begin
            if (row_ff == last_row_ff) begin
               state_in = ST_FILL_TAIL;
            end
         end
         ST_FILL_TAIL: state_in = ST_DIV;
         ST_DIV:       state_in = ST_DONE;
         ST_CLEAR: begin
            if (row_ff == '1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = row_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = row_ff;
      mem_wr_data = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            mem_rd_en   = req_fire;
            mem_rd_addr = req_row;
         end
         ST_FILL: begin
            mem_rd_en = 1'b1;
         end
         ST_DECIDE: begin
            mem_wr_en   = dec_write;
            mem_wr_data = mem_rd_data;
            mem_wr_data[dec_idx] = '{key: key_ff, score: score_ff};
         end
         ST_INIT, ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         index_bits_ff <= INDEX_BITS_RESET;
         rsp_tvalid_ff <= 1'b0;
         pend_ff       <= 1'b0;
         row_ff        <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= (state_ff == ST_FILL);
         if (csr_wr_en) begin
            index_bits_ff <= csr_wr_data;
         end
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT, ST_CLEAR, ST_FILL: begin
               row_ff <= row_ff + 1'b1;
            end
            ST_IDLE: begin
               if (req_fire) begin
                  row_ff <= ((req_op == OP_ADD) || (req_op == OP_LOOKUP)) ? req_row : '0;
               end
            end
            default: begin
               row_ff <= row_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         used_ff <= used_ff + row_pop;
      end
      case (state_ff)
         ST_IDLE: begin
            op_ff       <= req_op;
            key_ff      <= req_tdata[KEY_W-1:0];
            score_ff    <= req_tdata[KEY_W+SCORE_W-1:KEY_W];
            last_row_ff <= fill_last;
            way_ff      <= '0;
            match_ff    <= 1'b0;
            empty_ff    <= 1'b0;
            used_ff     <= '0;
         end
         ST_SCAN: begin
            way_ff <= way_ff + 1'b1;
            if (flags.key_eq && !match_ff) begin
               match_ff       <= 1'b1;
               match_idx_ff   <= way_ff;
               match_score_ff <= cur_slot.score;
               match_lt_ff    <= flags.lt_new;
            end
            if (flags.empty && !empty_ff) begin
               empty_ff     <= 1'b1;
               empty_idx_ff <= way_ff;
            end
            if ((way_ff == '0) || flags.lt_low) begin
               low_idx_ff   <= way_ff;
               low_score_ff <= cur_slot.score;
               low_lt_ff    <= flags.lt_new;
            end
         end
         ST_DECIDE: begin
            res_ok_ff    <= dec_ok;
            res_score_ff <= ((op_ff == OP_LOOKUP) && match_ff) ? match_score_ff : '0;
         end
         ST_DIV: begin
            used_ff <= div_prod[DIV_SH +: USED_W];
         end
         ST_DONE: begin
            if (out_free) begin
               case (op_ff)
                  OP_ADD, OP_LOOKUP: begin
                     rsp_tuser_ff <= res_ok_ff;
                     rsp_score_ff <= res_score_ff;
                     rsp_fill_ff  <= '0;
                  end
                  OP_FILL: begin
                     rsp_tuser_ff <= 1'b1;
                     rsp_score_ff <= '0;
                     rsp_fill_ff  <= used_ff[FILL_W-1:0];
                  end
                  default: begin
                     rsp_tuser_ff <= 1'b1;
                     rsp_score_ff <= '0;
                     rsp_fill_ff  <= '0;
                  end
               endcase
            end
         end
         default: begin
            way_ff <= way_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = {6'd0, rsp_fill_ff, rsp_score_ff};

endmodule

`default_nettype wire

// File: rtl/bst_checker.sv
// Port-level checker of the bucketed score table, bound to the top level.
// Depends on bucketed_score_table_assert.svh.
`default_nettype none

module bst_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire        rsp_tuser
);

`include "bucketed_score_table_assert.svh"

   `BST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "Stalled result changed.")
   `BST_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready, "Block took a second request at once.")
   `BST_ASSERT_SAME(a_fail_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 32'd0, "Failed result carries data.")
   `BST_ASSERT_SAME(a_one_field, clock, reset, rsp_tvalid, (rsp_tdata[15:0] == 16'd0) || (rsp_tdata[25:16] == 10'd0), "Score and fill both set.")
   `BST_ASSERT_SAME(a_fill_range, clock, reset, rsp_tvalid, rsp_tdata[25:16] <= 10'd1000, "Fill estimate above one thousand.")

endmodule

bind bucketed_score_table bst_checker u_bst_checker (.*);

`default_nettype wire
